### hw/rtl/shpr_pkg.sv
// ----------------------------------------------------------------------------
// Sensor hub packet report parser package
// Shared widths, codes and the result word type.
// ----------------------------------------------------------------------------
package shpr_pkg;

  localparam int unsigned LenW   = 15;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OffW   = 4;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ValW   = 16;
  localparam int unsigned NWords = 4;
  localparam int unsigned CfgW   = 15;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [LenW-1:0]  MaxLenReset  = 15'd300;
  localparam logic [ChanW-1:0] DataChReset  = 8'd3;
  localparam logic [LenW-1:0]  MinLen       = 15'd4;
  localparam logic [LenW-1:0]  HeaderLast   = 15'd3;
  localparam logic [LenW-1:0]  FirstRptPos  = 15'd9;

  localparam logic [CfgIdxW-1:0] CfgMaxLen = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDataCh = 1'd1;

  localparam logic [ByteW-1:0] IdRot  = 8'h05;
  localparam logic [ByteW-1:0] IdAcc  = 8'h04;
  localparam logic [ByteW-1:0] IdSkp1 = 8'h01;
  localparam logic [ByteW-1:0] IdSkp2 = 8'h02;
  localparam logic [ByteW-1:0] IdSkp3 = 8'h03;

  localparam logic [OffW-1:0] RotSize    = 4'd14;
  localparam logic [OffW-1:0] AccSize    = 4'd10;
  localparam logic [OffW-1:0] FirstWord  = 4'd4;
  localparam logic [OffW-1:0] RotWordEnd = 4'd12;
  localparam logic [OffW-1:0] AccWordEnd = 4'd10;

  localparam logic [KindW-1:0] KindRot    = 2'd0;
  localparam logic [KindW-1:0] KindAcc    = 2'd1;
  localparam logic [KindW-1:0] KindSkip   = 2'd2;
  localparam logic [KindW-1:0] KindBadLen = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HEADER,
    MODE_PAYLOAD
  } mode_t;

  typedef struct packed {
    logic [KindW-1:0]       report_kind;
    logic signed [ValW-1:0] value_x;
    logic signed [ValW-1:0] value_y;
    logic signed [ValW-1:0] value_z;
    logic signed [ValW-1:0] value_w;
  } report_t;

endpackage

### hw/rtl/shpr_if.sv
// ----------------------------------------------------------------------------
// Sensor hub packet report parser channels
// Valid/ready channels for received bytes and for parsed report words.
// ----------------------------------------------------------------------------
interface shpr_rx_if;
  logic                      valid;
  logic                      ready;
  logic [shpr_pkg::ByteW-1:0] rx_byte;
  logic                      packet_start;

  modport source (output valid, rx_byte, packet_start, input ready);
  modport sink (input valid, rx_byte, packet_start, output ready);
endinterface

interface shpr_report_if;
  logic                              valid;
  logic                              ready;
  logic [shpr_pkg::KindW-1:0]        report_kind;
  logic signed [shpr_pkg::ValW-1:0]  value_x;
  logic signed [shpr_pkg::ValW-1:0]  value_y;
  logic signed [shpr_pkg::ValW-1:0]  value_z;
  logic signed [shpr_pkg::ValW-1:0]  value_w;

  modport source (output valid, report_kind, value_x, value_y, value_z, value_w,
                  input ready);
  modport sink (input valid, report_kind, value_x, value_y, value_z, value_w,
                output ready);
endinterface

### hw/rtl/sensor_hub_packet_report_parser.sv
// ----------------------------------------------------------------------------
// Sensor hub packet report parser
// Walks sensor hub packets byte by byte and returns rotation vector and
// linear acceleration words, or an error word for a bad header length.
// A report word is registered when its last byte is accepted. Throughput:
// one byte per cycle, set by the single parse state update, while the skid
// entry is empty. A two-entry output register keeps bytes flowing while a
// word waits. Reset: parser idle, output empty, max length 300, data channel 3.
// ----------------------------------------------------------------------------
module sensor_hub_packet_report_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_en,
  input  logic [shpr_pkg::CfgIdxW-1:0]    write_index,
  input  logic [shpr_pkg::CfgW-1:0]       write_data,
  shpr_rx_if.sink                         rx,
  shpr_report_if.source                   report
);

  logic [shpr_pkg::LenW-1:0]  max_packet_len;
  logic [shpr_pkg::ChanW-1:0] data_channel;

  shpr_pkg::mode_t            parse_mode, parse_mode_next;
  logic [shpr_pkg::LenW-1:0]  byte_position, byte_position_next;
  logic [shpr_pkg::LenW-1:0]  packet_length, packet_length_next;
  logic [shpr_pkg::ChanW-1:0] packet_channel, packet_channel_next;
  logic [shpr_pkg::OffW-1:0]  report_offset, report_offset_next;
  logic [shpr_pkg::KindW-1:0] current_report, current_report_next;
  logic [shpr_pkg::ByteW-1:0] low_byte_hold, low_byte_hold_next;
  logic [shpr_pkg::ValW-1:0]  collected_words [shpr_pkg::NWords];
  logic [shpr_pkg::ValW-1:0]  collected_words_next [shpr_pkg::NWords];

  shpr_pkg::report_t out_word, skid_word, result;
  logic              out_valid, skid_valid;
  logic              emit;
  logic              accept, pop;

  shpr_pkg::mode_t           mode_eff;
  logic [shpr_pkg::LenW-1:0] pos;
  logic [shpr_pkg::LenW:0]   pos_inc;
  logic [shpr_pkg::OffW-1:0] off_inc, word_off, rpt_size, word_end;
  logic [shpr_pkg::ByteW-1:0] b;

  assign accept   = rx.valid && rx.ready;
  assign pop      = out_valid && report.ready;
  assign rx.ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len <= shpr_pkg::MaxLenReset;
      data_channel   <= shpr_pkg::DataChReset;
    end else if (write_en) begin
      if (write_index == shpr_pkg::CfgMaxLen) begin
        max_packet_len <= write_data[shpr_pkg::LenW-1:0];
      end else if (write_index == shpr_pkg::CfgDataCh) begin
        data_channel <= write_data[shpr_pkg::ChanW-1:0];
      end
    end
  end

  always_comb begin
    b        = rx.rx_byte;
    mode_eff = rx.packet_start ? shpr_pkg::MODE_HEADER : parse_mode;
    pos      = rx.packet_start ? '0 : byte_position;
    pos_inc  = {1'b0, pos} + 16'd1;
    off_inc  = report_offset + 4'd1;
    word_off = report_offset - shpr_pkg::FirstWord;
    rpt_size = (current_report == shpr_pkg::KindRot) ? shpr_pkg::RotSize
                                                      : shpr_pkg::AccSize;
    word_end = (current_report == shpr_pkg::KindRot) ? shpr_pkg::RotWordEnd :
               (current_report == shpr_pkg::KindAcc) ? shpr_pkg::AccWordEnd :
                                                        shpr_pkg::FirstWord;

    parse_mode_next     = mode_eff;
    byte_position_next  = pos;
    packet_length_next  = packet_length;
    packet_channel_next = packet_channel;
    report_offset_next  = report_offset;
    current_report_next = current_report;
    low_byte_hold_next  = low_byte_hold;
    collected_words_next = collected_words;
    emit                = 1'b0;
    result              = '0;

    unique case (mode_eff)
      shpr_pkg::MODE_IDLE: begin
      end
      shpr_pkg::MODE_HEADER: begin
        if (pos == 15'd0) begin
          packet_length_next = {7'd0, b};
        end else if (pos == 15'd1) begin
          packet_length_next = {b[6:0], packet_length[7:0]};
        end else if (pos == 15'd2) begin
          packet_channel_next = b;
        end
        byte_position_next = pos_inc[shpr_pkg::LenW-1:0];
        if (pos >= shpr_pkg::HeaderLast) begin
          if (packet_length < shpr_pkg::MinLen || packet_length > max_packet_len) begin
            emit               = 1'b1;
            result.report_kind = shpr_pkg::KindBadLen;
            parse_mode_next    = shpr_pkg::MODE_IDLE;
          end else if (packet_channel != data_channel) begin
            parse_mode_next = shpr_pkg::MODE_IDLE;
          end else begin
            report_offset_next = '0;
            parse_mode_next    = (pos_inc >= {1'b0, packet_length}) ?
                                 shpr_pkg::MODE_IDLE : shpr_pkg::MODE_PAYLOAD;
          end
        end
      end
      shpr_pkg::MODE_PAYLOAD: begin
        byte_position_next = pos_inc[shpr_pkg::LenW-1:0];
        if (pos_inc >= {1'b0, packet_length}) begin
          parse_mode_next = shpr_pkg::MODE_IDLE;
        end
        if (pos >= shpr_pkg::FirstRptPos) begin
          if (report_offset == '0) begin
            report_offset_next = 4'd1;
            if (b == shpr_pkg::IdRot) begin
              current_report_next = shpr_pkg::KindRot;
              if ({1'b0, pos} + 16'd14 > {1'b0, packet_length}) begin
                parse_mode_next = shpr_pkg::MODE_IDLE;
              end
            end else if (b == shpr_pkg::IdAcc) begin
              current_report_next = shpr_pkg::KindAcc;
              if ({1'b0, pos} + 16'd10 > {1'b0, packet_length}) begin
                parse_mode_next = shpr_pkg::MODE_IDLE;
              end
            end else if (b == shpr_pkg::IdSkp1 || b == shpr_pkg::IdSkp2 ||
                         b == shpr_pkg::IdSkp3) begin
              current_report_next = shpr_pkg::KindSkip;
            end else begin
              parse_mode_next = shpr_pkg::MODE_IDLE;
            end
          end else begin
            if (report_offset >= shpr_pkg::FirstWord && report_offset < word_end) begin
              if (!report_offset[0]) begin
                low_byte_hold_next = b;
              end else begin
                collected_words_next[word_off[2:1]] = {b, low_byte_hold};
              end
            end
            if (off_inc >= rpt_size) begin
              report_offset_next = '0;
              if (current_report != shpr_pkg::KindSkip) begin
                emit               = 1'b1;
                result.report_kind = current_report;
                result.value_x     = collected_words_next[0];
                result.value_y     = collected_words_next[1];
                result.value_z     = collected_words_next[2];
                result.value_w     = (current_report == shpr_pkg::KindRot) ?
                                     collected_words_next[3] : '0;
              end
            end else begin
              report_offset_next = off_inc;
            end
          end
        end
      end
      default: begin
        parse_mode_next = shpr_pkg::MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode     <= shpr_pkg::MODE_IDLE;
      byte_position  <= '0;
      packet_length  <= '0;
      packet_channel <= '0;
      report_offset  <= '0;
      current_report <= '0;
    end else if (accept) begin
      parse_mode     <= parse_mode_next;
      byte_position  <= byte_position_next;
      packet_length  <= packet_length_next;
      packet_channel <= packet_channel_next;
      report_offset  <= report_offset_next;
      current_report <= current_report_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      low_byte_hold   <= low_byte_hold_next;
      collected_words <= collected_words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept && emit) begin
      if (out_valid && !pop) begin
        skid_word  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_word  <= result;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign report.valid       = out_valid;
  assign report.report_kind = out_word.report_kind;
  assign report.value_x     = out_word.value_x;
  assign report.value_y     = out_word.value_y;
  assign report.value_z     = out_word.value_z;
  assign report.value_w     = out_word.value_w;

endmodule
